// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; they compile to nothing under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/dfm_pkg.sv =====
// ---------------------------------------------------------------------------
// dfm_pkg
// Types, constants and the cosine table of the DDS FSK byte modulator.
// ---------------------------------------------------------------------------
package dfm_pkg;

    // Fixed sizes
    localparam int TABLE_ENTRIES = 32;
    localparam int PHASE_WIDTH   = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int RATE_W        = 16;
    localparam int DATA_W        = 8;
    localparam int SAMPLE_W      = 8;
    localparam int PERIOD_W      = 15;   // 20000 samples at most
    localparam int BIT_IDX_W     = 3;    // eight bits per byte
    localparam int DIV_CNT_W     = 3;    // eight radix-4 steps for 16 bits

    // Tone and rate constants
    localparam int unsigned SAMPLE_RATE   = 20000;
    localparam int unsigned PHASE_MODULUS = 65536;
    localparam int unsigned MARK_FREQ     = 2200;
    localparam int unsigned SPACE_FREQ    = 1200;

    localparam logic [PHASE_WIDTH-1:0] MARK_STEP  =
        PHASE_WIDTH'(MARK_FREQ * PHASE_MODULUS / SAMPLE_RATE);
    localparam logic [PHASE_WIDTH-1:0] SPACE_STEP =
        PHASE_WIDTH'(SPACE_FREQ * PHASE_MODULUS / SAMPLE_RATE);
    localparam logic [RATE_W-1:0]      RATE_RESET = RATE_W'(1200);
    localparam logic [RATE_W-1:0]      DIVIDEND_RATE = RATE_W'(SAMPLE_RATE);
    localparam logic [DIV_CNT_W-1:0]   DIV_CNT_LAST  = '1;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_PERIOD,
        S_SET_PERIOD,
        S_DIV_BIT,
        S_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;       // latch the input byte
        logic start_period;  // load divider with sample rate / bit rate
        logic store_period;  // keep the clamped quotient as the bit period
        logic start_bit;     // load divider with bit timer / bit period
        logic step;          // one radix-4 divider step
        logic finish;        // emit sample, advance phase and bit timer
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;      // current divider step is the final one
        logic period_stale;  // bit rate changed since the period was computed
    } t_dp_status;

    // Unsigned 8-bit cosine table
    function automatic logic [SAMPLE_W-1:0] cos_rom(input logic [IDX_W-1:0] idx);
        logic [SAMPLE_W-1:0] v;
        unique case (idx)
            5'd0:  v = 8'd255;
            5'd1:  v = 8'd253;
            5'd2:  v = 8'd246;
            5'd3:  v = 8'd234;
            5'd4:  v = 8'd218;
            5'd5:  v = 8'd199;
            5'd6:  v = 8'd177;
            5'd7:  v = 8'd153;
            5'd8:  v = 8'd128;
            5'd9:  v = 8'd103;
            5'd10: v = 8'd79;
            5'd11: v = 8'd57;
            5'd12: v = 8'd38;
            5'd13: v = 8'd22;
            5'd14: v = 8'd10;
            5'd15: v = 8'd3;
            5'd16: v = 8'd0;
            5'd17: v = 8'd3;
            5'd18: v = 8'd10;
            5'd19: v = 8'd22;
            5'd20: v = 8'd38;
            5'd21: v = 8'd57;
            5'd22: v = 8'd79;
            5'd23: v = 8'd103;
            5'd24: v = 8'd128;
            5'd25: v = 8'd153;
            5'd26: v = 8'd177;
            5'd27: v = 8'd199;
            5'd28: v = 8'd218;
            5'd29: v = 8'd234;
            5'd30: v = 8'd246;
            5'd31: v = 8'd253;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/dfm_dpath.sv =====
// ---------------------------------------------------------------------------
// dfm_dpath
// Datapath: bit rate register, shared radix-4 divider, phase accumulator,
// bit timer and output sample register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfm_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dfm_pkg::t_dp_cmd               i_cmd,
    output dfm_pkg::t_dp_status            o_status,
    input  logic                           i_cfg_we,
    input  logic [dfm_pkg::RATE_W-1:0]     i_cfg_wdata,
    input  logic [dfm_pkg::DATA_W-1:0]     i_data_byte,
    output logic [dfm_pkg::SAMPLE_W-1:0]   o_sample
);

    localparam int RW = dfm_pkg::RATE_W;
    localparam int PW = dfm_pkg::PHASE_WIDTH;

    logic [RW-1:0]                    r_bit_rate;
    logic                             r_stale;
    logic [dfm_pkg::PERIOD_W-1:0]     r_period;
    logic [PW-1:0]                    r_phase;
    logic [RW-1:0]                    r_timer;
    logic [dfm_pkg::DATA_W-1:0]       r_data;
    logic [RW-1:0]                    r_rem;
    logic [RW-1:0]                    r_quo;
    logic [RW-1:0]                    r_div;
    logic [dfm_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [dfm_pkg::SAMPLE_W-1:0]     r_sample;

    logic [RW:0]                      w_r1;
    logic [RW:0]                      w_r2;
    logic [RW-1:0]                    w_rem1;
    logic [RW-1:0]                    n_rem;
    logic [RW-1:0]                    n_quo;
    logic                             w_b1;
    logic                             w_b2;
    logic [dfm_pkg::PERIOD_W-1:0]     w_period_new;
    logic [dfm_pkg::PERIOD_W-1:0]     w_period_src;
    logic [RW-1:0]                    w_rate_div;
    logic                             w_bit;
    logic [PW-1:0]                    w_step;
    logic [RW-1:0]                    w_timer_inc;
    logic                             w_timer_wrap;

    // Two restoring division steps per cycle, dividend bits shift out of quo
    always_comb begin
        w_r1   = {r_rem, r_quo[RW-1]};
        w_b1   = (w_r1 >= {1'b0, r_div});
        w_rem1 = w_b1 ? RW'(w_r1 - {1'b0, r_div}) : w_r1[RW-1:0];
        w_r2   = {w_rem1, r_quo[RW-2]};
        w_b2   = (w_r2 >= {1'b0, r_div});
        n_rem  = w_b2 ? RW'(w_r2 - {1'b0, r_div}) : w_r2[RW-1:0];
        n_quo  = {r_quo[RW-3:0], w_b1, w_b2};
    end

    // Clamp period to at least one sample; a zero rate divides as one
    always_comb begin
        w_period_new = (r_quo == '0) ? dfm_pkg::PERIOD_W'(1) : r_quo[dfm_pkg::PERIOD_W-1:0];
        w_period_src = i_cmd.store_period ? w_period_new : r_period;
        w_rate_div   = (r_bit_rate == '0) ? RW'(1) : r_bit_rate;
    end

    // Tone select, timer advance and restart bound
    always_comb begin
        w_bit        = r_data[r_quo[dfm_pkg::BIT_IDX_W-1:0]];
        w_step       = w_bit ? dfm_pkg::MARK_STEP : dfm_pkg::SPACE_STEP;
        w_timer_inc  = r_timer + RW'(1);
        w_timer_wrap = ({2'b00, w_timer_inc} >= {r_period, 3'b000});
    end

    // Configuration and stale flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_rate <= dfm_pkg::RATE_RESET;
            r_stale    <= 1'b1;
        end else if (i_cfg_we) begin
            r_bit_rate <= i_cfg_wdata;
            r_stale    <= 1'b1;
        end else if (i_cmd.store_period) begin
            r_stale    <= 1'b0;
        end
    end

    // Modulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_timer <= '0;
        end else if (i_cmd.finish) begin
            r_phase <= r_phase + w_step;
            r_timer <= w_timer_wrap ? '0 : w_timer_inc;
        end
    end

    // Payload registers: divider, period, byte and sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_data <= i_data_byte;
        end
        if (i_cmd.store_period) begin
            r_period <= w_period_new;
        end
        if (i_cmd.start_period) begin
            r_rem <= '0;
            r_quo <= dfm_pkg::DIVIDEND_RATE;
            r_div <= w_rate_div;
            r_cnt <= '0;
        end else if (i_cmd.start_bit) begin
            r_rem <= '0;
            r_quo <= r_timer;
            r_div <= {1'b0, w_period_src};
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + dfm_pkg::DIV_CNT_W'(1);
        end
        if (i_cmd.finish) begin
            r_sample <= dfm_pkg::cos_rom(r_phase[PW-1 -: dfm_pkg::IDX_W]);
        end
    end

    assign o_status.div_last     = (r_cnt == dfm_pkg::DIV_CNT_LAST);
    assign o_status.period_stale = r_stale;
    assign o_sample              = r_sample;

    // Divider keeps remainder below divisor while stepping
    `ASSERT_NEXT(a_rem_below_div, i_clk, i_rst_n, i_cmd.step, r_rem < r_div)
    // Stored period is never zero once computed
    `ASSERT_NEXT(a_period_nonzero, i_clk, i_rst_n, i_cmd.store_period, r_period != '0)

endmodule

// ===== src/dfm_ctrl.sv =====
// ---------------------------------------------------------------------------
// dfm_ctrl
// Controller: sequences period (when stale) and bit-index divisions for each
// sample transaction and owns the output valid flag.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dfm_pkg::t_dp_cmd      o_cmd,
    input  dfm_pkg::t_dp_status   i_status
);

    dfm_pkg::t_state r_state;
    dfm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            w_accept;
    logic            w_out_free;

    assign w_accept   = i_valid && (r_state == dfm_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dfm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            dfm_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.period_stale) begin
                        o_cmd.start_period = 1'b1;
                        n_state = dfm_pkg::S_DIV_PERIOD;
                    end else begin
                        o_cmd.start_bit = 1'b1;
                        n_state = dfm_pkg::S_DIV_BIT;
                    end
                end
            end
            dfm_pkg::S_DIV_PERIOD: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = dfm_pkg::S_SET_PERIOD;
                end
            end
            dfm_pkg::S_SET_PERIOD: begin
                o_cmd.store_period = 1'b1;
                o_cmd.start_bit    = 1'b1;
                n_state = dfm_pkg::S_DIV_BIT;
            end
            dfm_pkg::S_DIV_BIT: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = dfm_pkg::S_FINISH;
                end
            end
            dfm_pkg::S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = dfm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dfm_pkg::S_IDLE;
            end
        endcase
    end

    // Output valid: set on finish, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    // An accepted transaction leaves idle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, r_state != dfm_pkg::S_IDLE)
    // A finished sample is presented next cycle
    `ASSERT_NEXT(a_finish_valid, i_clk, i_rst_n, o_cmd.finish, o_valid)
    // Bit division always ends in the finish state
    `ASSERT_NEXT(a_bit_to_finish, i_clk, i_rst_n,
        (r_state == dfm_pkg::S_DIV_BIT) && i_status.div_last, r_state == dfm_pkg::S_FINISH)

endmodule

// ===== src/dds_fsk_byte_modulator_core.sv =====
// ---------------------------------------------------------------------------
// dds_fsk_byte_modulator_core
// Binary FSK modulator: one cosine sample per input tick, sending the data
// byte LSB first at the configured bit rate.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_ready    i_data_byte [7:0]
//  output    out        o_valid / i_ready    o_sample    [7:0]
//  config    in         i_cfg_we             i_cfg_wdata [15:0] (bit rate)
//
//  A transaction passes through the accepting (capture) cycle, eight
//  radix-4 steps of the shared divider (timer / period) and the finish state,
//  which a waiting sample can stall; the sample is registered on finish. After
//  reset or a bit rate write the first transaction also takes eight steps
//  dividing the sample rate by the bit rate and a state to store the period.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A waiting sample holds the next transaction in its finish cycle; that next
//  input is still accepted while the sample waits.
// ---------------------------------------------------------------------------
module dds_fsk_byte_modulator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dfm_pkg::DATA_W-1:0]     i_data_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dfm_pkg::SAMPLE_W-1:0]   o_sample,
    input  logic                           i_cfg_we,
    input  logic [dfm_pkg::RATE_W-1:0]     i_cfg_wdata
);

    dfm_pkg::t_dp_cmd    w_cmd;
    dfm_pkg::t_dp_status w_status;

    // Sequencer
    dfm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    // Divider, accumulator and sample datapath
    dfm_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_data_byte (i_data_byte),
        .o_sample    (o_sample)
    );

endmodule
